FILE: sv/clb_pkg.sv
// Shared definitions for the clipped glyph blitter: sizes, codes, payload structs
// and small coordinate helpers. No dependencies.
package clb_pkg;

  localparam int GLYPH_COUNT = 96;
  localparam int GLYPH_ROWS  = 24;
  localparam int COORD_BITS  = 12;
  localparam int FIRST_CODE  = 32;
  localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_BITS    = 12;
  localparam int ROW_W       = 5;
  localparam int COLOR_W     = 16;
  localparam int SIZE_W      = 13;
  localparam int CW          = COORD_BITS + 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int SCREEN_MAX  = 4096;

  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DRAW = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CFG_FONT_MODE    = 2'd0,
    CFG_TEXT_COLOR   = 2'd1,
    CFG_SCREEN_WIDTH = 2'd2,
    CFG_SCREEN_HEIGHT = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    BK_IDLE,
    BK_WALK
  } back_state_t;

  typedef struct packed {
    op_t                          opcode;
    logic [7:0]                   char_code;
    logic [ROW_W-1:0]             glyph_row;
    logic [ROW_BITS-1:0]          glyph_bits;
    logic signed [COORD_BITS-1:0] layer_sx;
    logic signed [COORD_BITS-1:0] layer_sy;
    logic signed [COORD_BITS-1:0] layer_ex;
    logic signed [COORD_BITS-1:0] layer_ey;
    logic signed [COORD_BITS-1:0] clip_sx;
    logic signed [COORD_BITS-1:0] clip_sy;
    logic signed [COORD_BITS-1:0] clip_ex;
    logic signed [COORD_BITS-1:0] clip_ey;
  } item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]        span_y;
    logic signed [COORD_BITS-1:0] span_origin_x;
    logic [ROW_BITS-1:0]          pixel_mask;
    logic [COLOR_W-1:0]           span_color;
    logic                         last_span;
  } span_t;

  typedef struct packed {
    logic               font_mode;
    logic [COLOR_W-1:0] text_color;
    logic [SIZE_W-1:0]  screen_width;
    logic [SIZE_W-1:0]  screen_height;
  } cfg_t;

  // One command between front and back end. For a load, addr is the store
  // entry and bits the row bitmap; for a draw, addr is the glyph base and
  // bits the column mask.
  typedef struct packed {
    op_t                          op;
    logic [ADDR_W-1:0]            addr;
    logic [ROW_BITS-1:0]          bits;
    logic [ROW_W-1:0]             row_first;
    logic [ROW_W-1:0]             row_last;
    logic [COORD_BITS-1:0]        y_first;
    logic signed [COORD_BITS-1:0] origin;
  } cmd_entry_t;

  function automatic coord_t sext(input logic signed [COORD_BITS-1:0] v);
    return coord_t'(v);
  endfunction

  function automatic coord_t smax(input coord_t a, input coord_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic coord_t smin(input coord_t a, input coord_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic coord_t sat(input coord_t v, input coord_t hi);
    coord_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Largest coordinate on an axis; a size of zero behaves as one.
  function automatic coord_t screen_max(input logic [SIZE_W-1:0] size);
    coord_t r;
    if (size == '0) begin
      r = '0;
    end else if (size > SIZE_W'(SCREEN_MAX)) begin
      r = CW'(SCREEN_MAX - 1);
    end else begin
      r = coord_t'({1'b0, size}) - coord_t'(1);
    end
    return r;
  endfunction

endpackage

FILE: sv/clb_queue.sv
// Short command queue between the front and back end of the glyph blitter.
// Depends on clb_pkg.
module clb_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  clb_pkg::cmd_entry_t push_data,
  input  logic                pop,
  output clb_pkg::cmd_entry_t pop_data,
  output logic                full,
  output logic                empty
);
  import clb_pkg::*;

  cmd_entry_t          slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full     = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/clb_front.sv
// Front end of the glyph blitter: takes items, checks codes, intersects the
// rectangles over two stages and queues the surviving commands. Depends on clb_pkg.
module clb_front (
  input  logic                clk,
  input  logic                rst,
  input  clb_pkg::item_t      cmd,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  clb_pkg::cfg_t       cfg,
  output logic                q_push,
  output clb_pkg::cmd_entry_t q_data,
  input  logic                q_full
);
  import clb_pkg::*;

  // Stage one: the raw item.
  logic  s1_v;
  item_t s1_item;

  // Stage two: partial intersection.
  logic                  s2_v;
  op_t                   s2_op;
  logic                  s2_code_ok;
  logic [ADDR_W-1:0]     s2_base;
  logic [ROW_W-1:0]      s2_row;
  logic [ROW_BITS-1:0]   s2_bits;
  coord_t                s2_lsx, s2_lsy, s2_ecol, s2_erow;
  coord_t                s2_xs0, s2_xe0, s2_ys0, s2_ye0;
  coord_t                s2_maxx, s2_maxy;

  logic [7:0]        glyph;
  logic              code_ok;
  logic [ADDR_W-1:0] base;
  coord_t            lsx, lsy, ecol, erow;

  always_comb begin
    glyph   = s1_item.char_code - 8'(FIRST_CODE);
    code_ok = (s1_item.char_code >= 8'(FIRST_CODE)) && (glyph < 8'(GLYPH_COUNT));
    base    = ADDR_W'(glyph * GLYPH_ROWS);
    lsx     = sext(s1_item.layer_sx);
    lsy     = sext(s1_item.layer_sy);
    ecol    = lsx + (cfg.font_mode ? coord_t'(11) : coord_t'(7));
    erow    = lsy + (cfg.font_mode ? coord_t'(23) : coord_t'(15));
  end

  coord_t                sx, ex, sy, ey, lo_c, hi_c;
  logic                  empty_rect;
  logic                  keep;
  logic [ROW_BITS-1:0]   colmask;

  always_comb begin
    sx = smax(sat(s2_xs0, s2_maxx), s2_lsx);
    ex = smin(sat(s2_xe0, s2_maxx), s2_ecol);
    sy = smax(sat(s2_ys0, s2_maxy), s2_lsy);
    ey = smin(sat(s2_ye0, s2_maxy), s2_erow);
    empty_rect = (sx > ex) || (sy > ey);
    lo_c = sx - s2_lsx;
    hi_c = ex - s2_lsx;
    for (int i = 0; i < ROW_BITS; i++) begin
      colmask[i] = (coord_t'(i) >= lo_c) && (coord_t'(i) <= hi_c);
    end
    if (s2_op == OP_LOAD) begin
      keep = s2_code_ok && (s2_row < ROW_W'(GLYPH_ROWS));
    end else begin
      keep = s2_code_ok && !empty_rect;
    end

    q_data.op        = s2_op;
    q_data.addr      = (s2_op == OP_LOAD) ? s2_base + ADDR_W'(s2_row) : s2_base;
    q_data.bits      = (s2_op == OP_LOAD) ? s2_bits : colmask;
    q_data.row_first = ROW_W'(sy - s2_lsy);
    q_data.row_last  = ROW_W'(ey - s2_lsy);
    q_data.y_first   = sy[COORD_BITS-1:0];
    q_data.origin    = s2_lsx[COORD_BITS-1:0];
  end

  logic s2_leave, s2_free, s1_move, accept;

  assign s2_leave  = s2_v && (!keep || !q_full);
  assign s2_free   = !s2_v || s2_leave;
  assign s1_move   = s1_v && s2_free;
  assign cmd_stall = s1_v && !s2_free;
  assign accept    = cmd_valid && !cmd_stall;
  assign q_push    = s2_v && keep && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      if (accept) begin
        s1_v <= 1'b1;
      end else if (s1_move) begin
        s1_v <= 1'b0;
      end
      if (s1_move) begin
        s2_v <= 1'b1;
      end else if (s2_leave) begin
        s2_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= cmd;
    end
    if (s1_move) begin
      s2_op      <= s1_item.opcode;
      s2_code_ok <= code_ok;
      s2_base    <= base;
      s2_row     <= s1_item.glyph_row;
      s2_bits    <= s1_item.glyph_bits;
      s2_lsx     <= lsx;
      s2_lsy     <= lsy;
      s2_ecol    <= ecol;
      s2_erow    <= erow;
      s2_xs0     <= smax(sext(s1_item.clip_sx), lsx);
      s2_xe0     <= smin(ecol, smin(sext(s1_item.clip_ex), sext(s1_item.layer_ex)));
      s2_ys0     <= smax(sext(s1_item.clip_sy), lsy);
      s2_ye0     <= smin(erow, smin(sext(s1_item.clip_ey), sext(s1_item.layer_ey)));
      s2_maxx    <= screen_max(cfg.screen_width);
      s2_maxy    <= screen_max(cfg.screen_height);
    end
  end

endmodule

FILE: sv/clb_back.sv
// Back end of the glyph blitter: owns the glyph store, performs loads and walks
// the rows of each draw into registered spans. Depends on clb_pkg.
module clb_back (
  input  logic                clk,
  input  logic                rst,
  input  clb_pkg::cfg_t       cfg,
  input  clb_pkg::cmd_entry_t q_data,
  input  logic                q_empty,
  output logic                q_pop,
  output clb_pkg::span_t      span,
  output logic                span_valid,
  input  logic                span_stall
);
  import clb_pkg::*;

  logic [ROW_BITS-1:0] store [STORE_DEPTH];
  logic [ROW_BITS-1:0] store_q;

  back_state_t state, state_next;

  logic [ROW_W-1:0]             cur_r, last_r;
  logic [COORD_BITS-1:0]        cur_y;
  logic [ADDR_W-1:0]            base;
  logic signed [COORD_BITS-1:0] origin;
  logic [ROW_BITS-1:0]          colmask;

  // Read stage: metadata travelling alongside the store read.
  logic                         rd_v;
  logic [COORD_BITS-1:0]        rd_y;
  logic signed [COORD_BITS-1:0] rd_origin;
  logic [ROW_BITS-1:0]          rd_colmask;
  logic                         rd_last;

  logic              out_take, rd_to_out, rd_free, issue, is_last;
  logic [ADDR_W-1:0] rd_addr;

  assign out_take  = span_valid && !span_stall;
  assign rd_to_out = rd_v && (!span_valid || out_take);
  assign rd_free   = !rd_v || rd_to_out;
  assign is_last   = (cur_r == last_r);
  assign rd_addr   = base + ADDR_W'(cur_r);

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    issue      = 1'b0;
    unique case (state)
      BK_IDLE: begin
        q_pop = !q_empty;
        if (!q_empty && (q_data.op == OP_DRAW)) begin
          state_next = BK_WALK;
        end
      end
      BK_WALK: begin
        issue = rd_free;
        if (rd_free && is_last) begin
          state_next = BK_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      rd_v       <= 1'b0;
      span_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (issue) begin
        rd_v <= 1'b1;
      end else if (rd_to_out) begin
        rd_v <= 1'b0;
      end
      if (rd_to_out) begin
        span_valid <= 1'b1;
      end else if (out_take) begin
        span_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_data.op == OP_LOAD)) begin
      store[q_data.addr] <= q_data.bits;
    end
    if (issue) begin
      store_q <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_data.op == OP_DRAW)) begin
      cur_r   <= q_data.row_first;
      last_r  <= q_data.row_last;
      cur_y   <= q_data.y_first;
      base    <= q_data.addr;
      origin  <= q_data.origin;
      colmask <= q_data.bits;
    end else if (issue) begin
      cur_r <= cur_r + 1'b1;
      cur_y <= cur_y + 1'b1;
    end
    if (issue) begin
      rd_y       <= cur_y;
      rd_origin  <= origin;
      rd_colmask <= colmask;
      rd_last    <= is_last;
    end
    if (rd_to_out) begin
      span.span_y        <= rd_y;
      span.span_origin_x <= rd_origin;
      span.pixel_mask    <= store_q & rd_colmask;
      span.span_color    <= cfg.text_color;
      span.last_span     <= rd_last;
    end
  end

endmodule

FILE: sv/clipped_glyph_blitter.sv
// Top level of the clipped glyph blitter: configuration registers and the
// front end, command queue and back end. Depends on clb_pkg and its submodules.
//
// A load item writes one 12-bit row into the glyph store; a draw item places one
// character cell at the layer origin, intersects it with the layer and clip
// rectangles and the screen, and produces one span per covered row, top row first,
// with last_span set on the final one. Codes outside the font, loads beyond the
// store and empty intersections produce nothing. Items pass through a two-stage
// front end and a four-entry command queue, so new items keep arriving while the
// back end is busy. The back end owns the glyph store's single read port: it takes
// a command from the queue while idle, performs a load as it is taken and walks a
// draw at one covered row per cycle while span_stall is low (at most 24 rows in 12
// by 24 mode, 16 in 8 by 16 mode). The store is not cleared at reset: drawing a
// glyph row that was never loaded gives an undefined mask. Configuration is taken
// on every cfg transfer (cfg_ready is always high) and must only be written while
// the block is idle.
module clipped_glyph_blitter (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_stall,
  input  clb_pkg::item_t           cmd,
  output logic                     span_valid,
  input  logic                     span_stall,
  output clb_pkg::span_t           span,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  clb_pkg::cfg_idx_t        cfg_index,
  input  logic [clb_pkg::COLOR_W-1:0] cfg_data
);
  import clb_pkg::*;

  cfg_t       cfg;
  logic       q_push, q_pop, q_full, q_empty;
  cmd_entry_t q_in, q_out;

  // The register port never back-pressures.
  assign cfg_ready = 1'b1;

  // Registers reset to the 8 by 16 font, colour zero and a 320 by 240 screen.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.font_mode     <= 1'b0;
      cfg.text_color    <= '0;
      cfg.screen_width  <= SIZE_W'(320);
      cfg.screen_height <= SIZE_W'(240);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FONT_MODE:     cfg.font_mode     <= cfg_data[0];
        CFG_TEXT_COLOR:    cfg.text_color    <= cfg_data;
        CFG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[SIZE_W-1:0];
        CFG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[SIZE_W-1:0];
      endcase
    end
  end

  // Front end: accepts items, classifies them and computes the clipped rows
  // and columns of each draw.
  clb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cfg       (cfg),
    .q_push    (q_push),
    .q_data    (q_in),
    .q_full    (q_full)
  );

  // The queue lets the front end keep accepting while spans are being walked.
  clb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back end: performs loads into the glyph store and emits one span per row.
  clb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_data     (q_out),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .span       (span),
    .span_valid (span_valid),
    .span_stall (span_stall)
  );

endmodule
